>>> rtl/rdpu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rdpu_pkg;

  // field widths
  localparam int DATA_W  = 32;
  localparam int DIGIT_W = 8;
  localparam int RADIX_W = 9;
  localparam int CELL_W  = 6;
  localparam int STEP_W  = $clog2(DATA_W);

  // register indexes
  localparam logic REG_RADIX      = 1'b0;
  localparam logic REG_CELL_COUNT = 1'b1;

  // register resets and radix limits
  localparam logic [RADIX_W-1:0] RADIX_RESET = 9'd2;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 9'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 9'd256;
  localparam logic [CELL_W-1:0]  CELL_RESET  = 6'd32;

  // item codes
  localparam logic MODE_PACK   = 1'b0;
  localparam logic MODE_UNPACK = 1'b1;
  localparam logic KIND_DIGIT  = 1'b0;
  localparam logic KIND_NUMBER = 1'b1;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_MUL_ACC = 5'b00010,
    ST_MUL_POW = 5'b00100,
    ST_DIV     = 5'b01000,
    ST_EMIT    = 5'b10000
  } state_t;

  // divider result bundle
  typedef struct packed {
    logic               done;
    logic [DATA_W-1:0]  quotient;
    logic [RADIX_W-1:0] remainder;
  } div_res_t;

endpackage

`default_nettype wire

>>> rtl/rdpu_divider.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module rdpu_divider (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [rdpu_pkg::DATA_W-1:0]  dividend,
  input  wire logic [rdpu_pkg::RADIX_W-1:0] divisor,
  output rdpu_pkg::div_res_t               res
);

  logic                        busy;
  logic                        done;
  logic [rdpu_pkg::STEP_W-1:0]  step;
  logic [rdpu_pkg::DATA_W-1:0]  quo;
  logic [rdpu_pkg::RADIX_W-1:0] rem;
  logic [rdpu_pkg::RADIX_W-1:0] dsr;

  // one trial subtract per cycle
  logic [rdpu_pkg::RADIX_W:0]   trial;
  logic                         fits;
  logic [rdpu_pkg::RADIX_W:0]   diff;

  always_comb begin
    trial = {rem, quo[rdpu_pkg::DATA_W-1]};
    fits  = (trial >= {1'b0, dsr});
    diff  = trial - {1'b0, dsr};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == rdpu_pkg::STEP_W'(rdpu_pkg::DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[rdpu_pkg::DATA_W-2:0], fits};
      rem <= fits ? diff[rdpu_pkg::RADIX_W-1:0] : trial[rdpu_pkg::RADIX_W-1:0];
    end
  end

  assign res.done      = done;
  assign res.quotient  = quo;
  assign res.remainder = rem;

endmodule

`default_nettype wire

>>> rtl/radix_digit_pack_unpack_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Radix digit pack / unpack core.
// Input channel (in_valid/in_ready): mode 0 carries one digit to pack,
// mode 1 carries one 32-bit number to split into digits.
// Output channel (out_valid/out_ready): kind 0 is one digit, least
// significant first, last set on the final digit; kind 1 is a packed
// number, always with last set.
// Pack: a digit passes the shared 32x9 multiplier in the accumulate step,
// then the place-weight step; the digit that completes the count (cell_count
// clamped to 1..MAX_CELLS) also yields a packed number via the emit step.
// Unpack: each digit comes from the bit-serial divider (loaded with the
// number, then with each quotient) and is handed off through the emit step.
// in_ready is high only while the sequencer is idle.
// Results sit in a single output register; a stalled receiver holds the
// sequencer in its emit step, with no item lost.
// Reset (rst, synchronous) sets radix 2, cell_count 32 and clears any
// partial pack and out_valid.
// Config writes (cfg_write) are taken at once and must come while idle.
module radix_digit_pack_unpack_core #(
  parameter int MAX_CELLS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic                         cfg_index,
  input  wire logic [rdpu_pkg::RADIX_W-1:0]  cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         mode,
  input  wire logic [rdpu_pkg::DIGIT_W-1:0]  digit_in,
  input  wire logic [rdpu_pkg::DATA_W-1:0]   number_in,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              kind,
  output logic [rdpu_pkg::DIGIT_W-1:0]       digit_out,
  output logic [rdpu_pkg::DATA_W-1:0]        number_out,
  output logic                              last
);

  localparam int KW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

  rdpu_pkg::state_t state;

  logic [rdpu_pkg::RADIX_W-1:0] radix;
  logic [rdpu_pkg::CELL_W-1:0]  cell_count;
  logic [rdpu_pkg::DATA_W-1:0]  accumulator;
  logic [rdpu_pkg::DATA_W-1:0]  place_weight;
  logic [rdpu_pkg::CELL_W-1:0]  digit_index;
  logic [rdpu_pkg::DIGIT_W-1:0] digit;
  logic [KW-1:0]                k;
  logic                         emit_pack;

  // effective radix and cell count
  logic [rdpu_pkg::RADIX_W-1:0] base;
  logic [6:0]                   count;

  always_comb begin
    if (radix < rdpu_pkg::RADIX_MIN)      base = rdpu_pkg::RADIX_MIN;
    else if (radix > rdpu_pkg::RADIX_MAX) base = rdpu_pkg::RADIX_MAX;
    else                                  base = radix;
    if (cell_count == '0)                         count = 7'd1;
    else if ({1'b0, cell_count} > 7'(MAX_CELLS))  count = 7'(MAX_CELLS);
    else                                          count = {1'b0, cell_count};
  end

  // shared multiplier: digit times weight, then weight times base
  logic [rdpu_pkg::RADIX_W-1:0]           mul_b;
  logic [rdpu_pkg::DATA_W+rdpu_pkg::RADIX_W-1:0] mul_p;

  assign mul_b = (state == rdpu_pkg::ST_MUL_ACC) ? {1'b0, digit} : base;
  assign mul_p = place_weight * mul_b;

  // pack completion
  logic [rdpu_pkg::CELL_W-1:0] index_next;
  logic                        pack_done;

  assign index_next = digit_index + 1'b1;
  assign pack_done  = (index_next == '0) || ({1'b0, index_next} >= count);

  // divider
  rdpu_pkg::div_res_t          div_res;
  logic                        div_start;
  logic [rdpu_pkg::DATA_W-1:0] div_dividend;
  logic                        in_take;
  logic                        slot_free;
  logic                        digit_last;

  assign in_ready   = (state == rdpu_pkg::ST_IDLE);
  assign in_take    = in_valid && in_ready;
  assign slot_free  = !out_valid || out_ready;
  assign digit_last = ((7'(k) + 7'd1) == count);

  assign div_dividend = (state == rdpu_pkg::ST_IDLE) ? number_in : div_res.quotient;
  assign div_start    = (in_take && mode == rdpu_pkg::MODE_UNPACK) ||
                        (state == rdpu_pkg::ST_EMIT && !emit_pack && slot_free &&
                         !digit_last);

  rdpu_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (base),
    .res      (div_res)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radix      <= rdpu_pkg::RADIX_RESET;
      cell_count <= rdpu_pkg::CELL_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        rdpu_pkg::REG_RADIX:      radix      <= cfg_data;
        rdpu_pkg::REG_CELL_COUNT: cell_count <= cfg_data[rdpu_pkg::CELL_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and pack state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rdpu_pkg::ST_IDLE;
      accumulator  <= '0;
      place_weight <= 32'd1;
      digit_index  <= '0;
      emit_pack    <= 1'b0;
      k            <= '0;
    end else begin
      case (state)
        rdpu_pkg::ST_IDLE: begin
          if (in_take) begin
            if (mode == rdpu_pkg::MODE_PACK) begin
              state <= rdpu_pkg::ST_MUL_ACC;
            end else begin
              accumulator  <= '0;
              place_weight <= 32'd1;
              digit_index  <= '0;
              k            <= '0;
              state        <= rdpu_pkg::ST_DIV;
            end
          end
        end
        rdpu_pkg::ST_MUL_ACC: begin
          accumulator <= accumulator + mul_p[rdpu_pkg::DATA_W-1:0];
          state       <= rdpu_pkg::ST_MUL_POW;
        end
        rdpu_pkg::ST_MUL_POW: begin
          place_weight <= mul_p[rdpu_pkg::DATA_W-1:0];
          digit_index  <= index_next;
          if (pack_done) begin
            emit_pack <= 1'b1;
            state     <= rdpu_pkg::ST_EMIT;
          end else begin
            state <= rdpu_pkg::ST_IDLE;
          end
        end
        rdpu_pkg::ST_DIV: begin
          if (div_res.done) begin
            emit_pack <= 1'b0;
            state     <= rdpu_pkg::ST_EMIT;
          end
        end
        rdpu_pkg::ST_EMIT: begin
          if (slot_free) begin
            if (emit_pack) begin
              accumulator  <= '0;
              place_weight <= 32'd1;
              digit_index  <= '0;
              state        <= rdpu_pkg::ST_IDLE;
            end else if (digit_last) begin
              state <= rdpu_pkg::ST_IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= rdpu_pkg::ST_DIV;
            end
          end
        end
        default: state <= rdpu_pkg::ST_IDLE;
      endcase
    end
  end

  // latch the digit of a pack item
  always_ff @(posedge clk) begin
    if (in_take) digit <= digit_in;
  end

  // output register
  logic out_load;
  assign out_load = (state == rdpu_pkg::ST_EMIT) && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (emit_pack) begin
        kind       <= rdpu_pkg::KIND_NUMBER;
        digit_out  <= '0;
        number_out <= accumulator;
        last       <= 1'b1;
      end else begin
        kind       <= rdpu_pkg::KIND_DIGIT;
        digit_out  <= div_res.remainder[rdpu_pkg::DIGIT_W-1:0];
        number_out <= '0;
        last       <= digit_last;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/rdpu_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module rdpu_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic                        kind,
  input wire logic [rdpu_pkg::DIGIT_W-1:0] digit_out,
  input wire logic [rdpu_pkg::DATA_W-1:0]  number_out,
  input wire logic                        last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(digit_out) &&
                                $stable(number_out) && $stable(last))
    else $error("stalled result changed");

  // a packed number always closes its run and carries no digit
  a_number_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == rdpu_pkg::KIND_NUMBER |-> last && digit_out == '0)
    else $error("packed number result malformed");

  // a digit result carries no number
  a_digit_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == rdpu_pkg::KIND_DIGIT |-> number_out == '0)
    else $error("digit result carries a number");

  // an accepted item drops in_ready in the following cycle
  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready straight after an accepted item");

endmodule

bind radix_digit_pack_unpack_core rdpu_checker u_rdpu_checker (.*);

`default_nettype wire
